### rtl/pgw_pkg.sv
// shared types, codes and the descriptor helper of the page table builder and walker
package pgw_pkg;

  localparam int TABLE_COUNT_DEF = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W = 9;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TABLE = 2'd1;
  localparam logic [1:0] ST_WINDOW   = 2'd2;
  localparam logic [1:0] ST_CONFLICT = 2'd3;

  // register indexes
  localparam logic [2:0] REG_TEXT_START = 3'd0;
  localparam logic [2:0] REG_TEXT_END   = 3'd1;
  localparam logic [2:0] REG_VEC_START  = 3'd2;
  localparam logic [2:0] REG_VEC_END    = 3'd3;
  localparam logic [2:0] REG_RO_START   = 3'd4;
  localparam logic [2:0] REG_RO_END     = 3'd5;
  localparam logic [2:0] REG_POOL_BASE  = 3'd6;

  typedef struct packed {
    logic [31:0] text_start;
    logic [31:0] text_end;
    logic [31:0] vectors_start;
    logic [31:0] vectors_end;
    logic [31:0] rodata_start;
    logic [31:0] rodata_end;
    logic [30:0] pool_base;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_CLEAR, S_OUT
  } state_t;

  // leaf descriptor for a page below 2 GiB
  function automatic logic [63:0] leaf_desc(input logic [18:0] pg, input logic dev,
                                            input cfg_t c);
    logic [32:0] p0;
    logic [32:0] p1;
    logic txt;
    logic ro;
    logic [11:0] low;
    p0 = {2'b00, pg, 12'h000};
    p1 = p0 + 33'h1000;
    txt = (p0 < {1'b0, c.text_end} && {1'b0, c.text_start} < p1) ||
          (p0 < {1'b0, c.vectors_end} && {1'b0, c.vectors_start} < p1);
    ro = txt || (p0 < {1'b0, c.rodata_end} && {1'b0, c.rodata_start} < p1);
    if (dev) begin
      leaf_desc = {9'd0, 1'b1, 1'b1, 22'd0, pg, 12'h703};
    end else begin
      low = ro ? 12'h787 : 12'h707;
      leaf_desc = {9'd0, ~txt, ~txt, 22'd0, pg, low};
    end
  endfunction

endpackage

### rtl/pgw_mem.sv
// table store: one write port, one registered read port
module pgw_mem #(
  parameter int DEPTH = 32768,
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pgw_cfg.sv
// configuration registers behind the apb-style port
module pgw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pgw_pkg::CFG_AW-1:0]    paddr,
  input  logic [pgw_pkg::CFG_DW-1:0]    pwdata,
  output logic [pgw_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output pgw_pkg::cfg_t                 cfg
);

  pgw_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr;

  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        pgw_pkg::REG_TEXT_START: cfg_r.text_start <= pwdata;
        pgw_pkg::REG_TEXT_END:   cfg_r.text_end <= pwdata;
        pgw_pkg::REG_VEC_START:  cfg_r.vectors_start <= pwdata;
        pgw_pkg::REG_VEC_END:    cfg_r.vectors_end <= pwdata;
        pgw_pkg::REG_RO_START:   cfg_r.rodata_start <= pwdata;
        pgw_pkg::REG_RO_END:     cfg_r.rodata_end <= pwdata;
        pgw_pkg::REG_POOL_BASE:  cfg_r.pool_base <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      pgw_pkg::REG_TEXT_START: prdata = cfg_r.text_start;
      pgw_pkg::REG_TEXT_END:   prdata = cfg_r.text_end;
      pgw_pkg::REG_VEC_START:  prdata = cfg_r.vectors_start;
      pgw_pkg::REG_VEC_END:    prdata = cfg_r.vectors_end;
      pgw_pkg::REG_RO_START:   prdata = cfg_r.rodata_start;
      pgw_pkg::REG_RO_END:     prdata = cfg_r.rodata_end;
      pgw_pkg::REG_POOL_BASE:  prdata = {1'b0, cfg_r.pool_base};
      default:                 prdata = '0;
    endcase
  end

endmodule

### rtl/page_table_builder_walker_unit.sv
// top level: sequencer that builds and walks the page tables in the table store
//
// Input channel (in_valid/in_stall) takes one transaction: in_operation,
// in_page_address, in_is_device. Each transaction gives exactly one result
// transaction on the output channel (out_status, out_descriptor).
// One transaction is worked on at a time; in_stall is high while busy.
// Start clears the 512 root entries. Lookup reads one entry per level
// for four levels. Map clears each newly allocated table as well, with
// the clear sweep writing one entry per cycle.
// Configuration registers sit on the apb-style port; pready is always high.
// Reset clears the allocator and the root flag; the table store contents
// stay undefined and each table is cleared when it is allocated.
// A finished result waits in the output register while out_stall is high;
// the block may take the next transaction meanwhile but holds its next
// result until the previous one is taken.
module page_table_builder_walker_unit #(
  parameter int TABLE_COUNT = pgw_pkg::TABLE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [38:0]                 in_page_address,
  input  logic                        in_is_device,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [63:0]                 out_descriptor,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pgw_pkg::CFG_AW-1:0]  paddr,
  input  logic [pgw_pkg::CFG_DW-1:0]  pwdata,
  output logic [pgw_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int UW = $clog2(TABLE_COUNT + 1);
  localparam int AW = TW + pgw_pkg::IDX_W;
  localparam int DEPTH = TABLE_COUNT * pgw_pkg::ENTRIES_PER_TABLE;
  localparam logic [UW-1:0] TC = UW'(TABLE_COUNT);
  localparam logic [pgw_pkg::IDX_W-1:0] LAST_IDX = {pgw_pkg::IDX_W{1'b1}};

  pgw_pkg::cfg_t   cfg;
  pgw_pkg::state_t state_r, state_nxt;

  logic [1:0]      level_r, level_nxt;
  logic [TW-1:0]   table_r, table_nxt;
  logic [pgw_pkg::IDX_W-1:0] clr_r, clr_nxt;
  logic            start_r, start_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [38:0]     addr_r, addr_nxt;
  logic            dev_r, dev_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic            root_r, root_nxt;
  logic [1:0]      res_st_r, res_st_nxt;
  logic [63:0]     res_d_r, res_d_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_st_r, out_st_nxt;
  logic [63:0]     out_d_r, out_d_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [63:0]     mem_wdata, mem_rdata;

  logic [pgw_pkg::IDX_W-1:0] idx;
  logic [51:0]     diff;
  logic            link_ok;
  logic [63:0]     link_d;
  logic [63:0]     leaf_d;
  logic [19:0]     link_hi;

  pgw_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pgw_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // entry index for the current level
  always_comb begin
    case (level_r)
      2'd0:    idx = '0;
      2'd1:    idx = addr_r[38:30];
      2'd2:    idx = addr_r[29:21];
      default: idx = addr_r[20:12];
    endcase
  end

  // table link decode and build
  assign diff = mem_rdata[63:12] - {33'd0, cfg.pool_base[30:12]};
  assign link_ok = (mem_rdata[1:0] == 2'b11) && (diff < {{(52-UW){1'b0}}, used_r});
  assign link_hi = {1'b0, cfg.pool_base[30:12]} + 20'(used_r);
  assign link_d = {32'd0, link_hi, 12'h003};
  assign leaf_d = pgw_pkg::leaf_desc(addr_r[30:12], dev_r, cfg);

  assign in_stall = (state_r != pgw_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_st_r;
  assign out_descriptor = out_d_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgw_pkg::S_IDLE;
      used_r <= '0;
      root_r <= 1'b0;
      out_valid_r <= 1'b0;
      level_r <= '0;
      clr_r <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      root_r <= root_nxt;
      out_valid_r <= out_valid_nxt;
      level_r <= level_nxt;
      clr_r <= clr_nxt;
      start_r <= start_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    table_r <= table_nxt;
    op_r <= op_nxt;
    addr_r <= addr_nxt;
    dev_r <= dev_nxt;
    res_st_r <= res_st_nxt;
    res_d_r <= res_d_nxt;
    out_st_r <= out_st_nxt;
    out_d_r <= out_d_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    table_nxt = table_r;
    clr_nxt = clr_r;
    start_nxt = start_r;
    op_nxt = op_r;
    addr_nxt = addr_r;
    dev_nxt = dev_r;
    used_nxt = used_r;
    root_nxt = root_r;
    res_st_nxt = res_st_r;
    res_d_nxt = res_d_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt = out_st_r;
    out_d_nxt = out_d_r;
    mem_we = 1'b0;
    mem_waddr = {table_r, idx};
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = {table_r, idx};
    case (state_r)
      pgw_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          addr_nxt = in_page_address;
          dev_nxt = in_is_device;
          level_nxt = '0;
          table_nxt = '0;
          res_st_nxt = pgw_pkg::ST_OK;
          res_d_nxt = '0;
          case (in_operation)
            pgw_pkg::OP_START: begin
              used_nxt = UW'(1);
              root_nxt = 1'b1;
              clr_nxt = '0;
              start_nxt = 1'b1;
              state_nxt = pgw_pkg::S_CLEAR;
            end
            pgw_pkg::OP_MAP: begin
              if (in_page_address[38:31] != 8'd0) begin
                res_st_nxt = pgw_pkg::ST_WINDOW;
                state_nxt = pgw_pkg::S_OUT;
              end else if (!root_r) begin
                res_st_nxt = pgw_pkg::ST_NO_TABLE;
                state_nxt = pgw_pkg::S_OUT;
              end else begin
                state_nxt = pgw_pkg::S_READ;
              end
            end
            pgw_pkg::OP_LOOKUP: begin
              state_nxt = root_r ? pgw_pkg::S_READ : pgw_pkg::S_OUT;
            end
            default: state_nxt = pgw_pkg::S_OUT;
          endcase
        end
      end
      pgw_pkg::S_READ: begin
        mem_re = 1'b1;
        state_nxt = pgw_pkg::S_EVAL;
      end
      pgw_pkg::S_EVAL: begin
        if (level_r == 2'd3) begin
          // leaf level
          if (op_r == pgw_pkg::OP_LOOKUP) begin
            res_d_nxt = mem_rdata;
          end else if (mem_rdata != 64'd0 && mem_rdata != leaf_d) begin
            res_st_nxt = pgw_pkg::ST_CONFLICT;
          end else begin
            mem_we = 1'b1;
            mem_wdata = leaf_d;
            res_d_nxt = leaf_d;
          end
          state_nxt = pgw_pkg::S_OUT;
        end else if (op_r == pgw_pkg::OP_MAP && mem_rdata == 64'd0) begin
          // allocate and link a new table
          if (used_r >= TC) begin
            res_st_nxt = pgw_pkg::ST_NO_TABLE;
            state_nxt = pgw_pkg::S_OUT;
          end else begin
            mem_we = 1'b1;
            mem_wdata = link_d;
            table_nxt = used_r[TW-1:0];
            used_nxt = used_r + UW'(1);
            clr_nxt = '0;
            start_nxt = 1'b0;
            state_nxt = pgw_pkg::S_CLEAR;
          end
        end else if (link_ok) begin
          table_nxt = diff[TW-1:0];
          level_nxt = level_r + 2'd1;
          state_nxt = pgw_pkg::S_READ;
        end else begin
          if (op_r == pgw_pkg::OP_MAP) begin
            res_st_nxt = pgw_pkg::ST_CONFLICT;
          end
          state_nxt = pgw_pkg::S_OUT;
        end
      end
      pgw_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = {table_r, clr_r};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          if (start_r) begin
            state_nxt = pgw_pkg::S_OUT;
          end else begin
            level_nxt = level_r + 2'd1;
            state_nxt = pgw_pkg::S_READ;
          end
        end
      end
      pgw_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_d_nxt = res_d_r;
          state_nxt = pgw_pkg::S_IDLE;
        end
      end
      default: state_nxt = pgw_pkg::S_IDLE;
    endcase
  end

  // checks
  a_root_used: assert property (@(posedge clk) disable iff (!rst_n)
    root_r |-> used_r != '0) else $error("root present with empty pool");
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= TC) else $error("pool count beyond table count");
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pgw_pkg::S_CLEAR |=> state_r == pgw_pkg::S_CLEAR ||
      state_r == pgw_pkg::S_READ || state_r == pgw_pkg::S_OUT)
    else $error("bad exit from clear sweep");
  a_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != pgw_pkg::ST_OK |-> out_d_r == 64'd0)
    else $error("error status with nonzero descriptor");

endmodule
